### rtl/buart_pkg.sv
// ----------------------------------------------------------------------------
// buart_pkg: shared types and helpers for the buffered UART ring front end
// Ring pointer arithmetic, command and result records, status codes.
// ----------------------------------------------------------------------------
package buart_pkg;

	localparam int RING_DEPTH = 64;
	localparam int IDX_W      = $clog2(RING_DEPTH);
	localparam int PTR_W      = $clog2(2 * RING_DEPTH);
	localparam int FILL_W     = 7;

	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(2 * RING_DEPTH - 1);
	localparam logic [PTR_W-1:0] DEPTH_P  = PTR_W'(RING_DEPTH);

	typedef enum logic [2:0] {
		FN_OPEN    = 3'd0,
		FN_CLOSE   = 3'd1,
		FN_WRITE   = 3'd2,
		FN_READ    = 3'd3,
		FN_SERVICE = 3'd4
	} func_e;

	typedef enum logic [2:0] {
		OP_NONE,
		OP_OPEN,
		OP_CLOSE,
		OP_WRITE,
		OP_READ,
		OP_SERVICE
	} op_e;

	typedef enum logic [2:0] {
		ST_OK       = 3'd0,
		ST_CLOSED   = 3'd1,
		ST_BUSY     = 3'd2,
		ST_RX_EMPTY = 3'd3,
		ST_TX_FULL  = 3'd4
	} status_e;

	typedef struct packed {
		op_e        op;
		logic [7:0] host_byte;
		logic       data_ready;
		logic       thr_empty;
		logic [7:0] rx_byte;
	} cmd_t;

	typedef struct packed {
		status_e           status;
		logic [7:0]        read_byte;
		logic              read_valid;
		logic [7:0]        tx_byte;
		logic              tx_valid;
		logic              taken;
		logic              ready_en;
		logic              empty_en;
		logic [FILL_W-1:0] rx_fill;
		logic [FILL_W-1:0] tx_fill;
	} res_t;

	// Pointers run modulo twice the depth so that full and empty differ.
	function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
		return (p == PTR_LAST) ? '0 : p + 1'b1;
	endfunction

	function automatic logic [IDX_W-1:0] ptr_slot(input logic [PTR_W-1:0] p);
		logic [PTR_W-1:0] s;
		s = (p >= DEPTH_P) ? p - DEPTH_P : p;
		return s[IDX_W-1:0];
	endfunction

	function automatic logic [PTR_W-1:0] ptr_fill(input logic [PTR_W-1:0] head,
	                                               input logic [PTR_W-1:0] tail);
		logic [PTR_W:0] d;
		if (tail >= head) begin
			d = {1'b0, tail} - {1'b0, head};
		end else begin
			d = {1'b0, tail} + (PTR_W + 1)'(2 * RING_DEPTH) - {1'b0, head};
		end
		return d[PTR_W-1:0];
	endfunction

	function automatic logic [FILL_W-1:0] fill_out(input logic [PTR_W-1:0] f);
		logic [31:0] w;
		w = 32'(f);
		return w[FILL_W-1:0];
	endfunction

endpackage

### rtl/buart_ram.sv
// ----------------------------------------------------------------------------
// buart_ram: generic single-write, single-read RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module buart_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

### rtl/buart_front.sv
// ----------------------------------------------------------------------------
// buart_front: request intake and decode
// Decodes each request into a command and holds it in a two-entry queue
// until the back end takes it.
// ----------------------------------------------------------------------------
module buart_front (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	output logic            full,
	input  logic [2:0]      func,
	input  logic [7:0]      host_byte,
	input  logic            line_data_ready,
	input  logic            line_thr_empty,
	input  logic [7:0]      line_rx_byte,
	output buart_pkg::cmd_t cmd,
	output logic            cmd_valid,
	input  logic            cmd_take
);
	import buart_pkg::*;

	logic [1:0] count_q;
	logic       wr_q;
	logic       rd_q;
	cmd_t       slot_q [2];
	cmd_t       cmd_in;
	op_e        op;
	logic       push_ok;
	logic       take;

	always_comb begin
		unique case (func)
			FN_OPEN:    op = OP_OPEN;
			FN_CLOSE:   op = OP_CLOSE;
			FN_WRITE:   op = OP_WRITE;
			FN_READ:    op = OP_READ;
			FN_SERVICE: op = OP_SERVICE;
			default:    op = OP_NONE;
		endcase
	end

	assign cmd_in = '{op: op, host_byte: host_byte, data_ready: line_data_ready,
	                  thr_empty: line_thr_empty, rx_byte: line_rx_byte};

	assign full      = (count_q == 2'd2);
	assign cmd_valid = (count_q != 2'd0);
	assign push_ok   = push && !full;
	assign take      = cmd_take && cmd_valid;
	assign cmd       = slot_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			wr_q    <= 1'b0;
			rd_q    <= 1'b0;
		end else begin
			if (push_ok) begin
				wr_q <= !wr_q;
			end
			if (take) begin
				rd_q <= !rd_q;
			end
			count_q <= count_q + 2'(push_ok) - 2'(take);
		end
	end

	always_ff @(posedge clk) begin
		if (push_ok) begin
			slot_q[wr_q] <= cmd_in;
		end
	end

endmodule

### rtl/buart_back.sv
// ----------------------------------------------------------------------------
// buart_back: ring and interrupt-enable execution
// Carries out one command against the receive and transmit rings, then
// forms the result once the ring read data is back, and holds it for pop.
// ----------------------------------------------------------------------------
module buart_back (
	input  logic            clk,
	input  logic            arst_n,
	input  buart_pkg::cmd_t cmd,
	input  logic            cmd_valid,
	output logic            cmd_take,
	output logic            empty,
	input  logic            pop,
	output buart_pkg::res_t res
);
	import buart_pkg::*;

	logic [PTR_W-1:0] rx_head_q, rx_tail_q, tx_head_q, tx_tail_q;
	logic             open_q, rdy_en_q, emp_en_q;

	logic [PTR_W-1:0] n_rx_head, n_rx_tail, n_tx_head, n_tx_tail;
	logic             n_open, n_rdy, n_emp;
	logic [PTR_W-1:0] rx_fill, tx_fill;
	status_e          status;
	logic             rx_pop, tx_pop, rx_push, tx_push, taken;
	logic             issue;

	logic             valid_s2;
	res_t             res_s2;
	logic             rx_pop_s2, tx_pop_s2;

	logic [7:0]       rx_rdata, tx_rdata;
	res_t             res_fin;
	res_t             out_q;
	logic             out_valid_q;

	assign issue    = cmd_valid && !valid_s2 && (!out_valid_q || pop);
	assign cmd_take = issue;
	assign rx_fill  = ptr_fill(rx_head_q, rx_tail_q);
	assign tx_fill  = ptr_fill(tx_head_q, tx_tail_q);

	always_comb begin
		n_rx_head = rx_head_q;
		n_rx_tail = rx_tail_q;
		n_tx_head = tx_head_q;
		n_tx_tail = tx_tail_q;
		n_open    = open_q;
		n_rdy     = rdy_en_q;
		n_emp     = emp_en_q;
		status    = ST_OK;
		rx_pop    = 1'b0;
		tx_pop    = 1'b0;
		rx_push   = 1'b0;
		tx_push   = 1'b0;
		taken     = 1'b0;
		if (cmd.op != OP_NONE && cmd.op != OP_OPEN && !open_q) begin
			status = ST_CLOSED;
		end else begin
			unique case (cmd.op)
				OP_OPEN: begin
					if (open_q) begin
						status = ST_BUSY;
					end else begin
						n_rx_head = '0;
						n_rx_tail = '0;
						n_tx_head = '0;
						n_tx_tail = '0;
						n_rdy     = 1'b1;
						n_emp     = 1'b0;
						n_open    = 1'b1;
					end
				end
				OP_CLOSE: begin
					n_rdy  = 1'b0;
					n_emp  = 1'b0;
					n_open = 1'b0;
				end
				OP_WRITE: begin
					if (tx_fill == DEPTH_P) begin
						status = ST_TX_FULL;
					end else begin
						tx_push   = 1'b1;
						n_tx_tail = ptr_next(tx_tail_q);
					end
					n_emp = 1'b1;
				end
				OP_READ: begin
					if (rx_fill == '0) begin
						status = ST_RX_EMPTY;
						n_rdy  = 1'b1;
					end else begin
						rx_pop    = 1'b1;
						n_rx_head = ptr_next(rx_head_q);
					end
				end
				OP_SERVICE: begin
					if (cmd.data_ready) begin
						if (rx_fill != DEPTH_P) begin
							rx_push   = 1'b1;
							taken     = 1'b1;
							n_rx_tail = ptr_next(rx_tail_q);
						end else begin
							n_rdy = 1'b0;
						end
					end
					if (cmd.thr_empty) begin
						if (tx_fill != '0) begin
							tx_pop    = 1'b1;
							n_tx_head = ptr_next(tx_head_q);
						end else begin
							n_emp = 1'b0;
						end
					end
				end
				default: begin
				end
			endcase
		end
	end

	buart_ram #(.WIDTH(8), .DEPTH(RING_DEPTH)) u_rx_ram (
		.clk   (clk),
		.we    (issue && rx_push),
		.waddr (ptr_slot(rx_tail_q)),
		.wdata (cmd.rx_byte),
		.raddr (ptr_slot(rx_head_q)),
		.rdata (rx_rdata)
	);

	buart_ram #(.WIDTH(8), .DEPTH(RING_DEPTH)) u_tx_ram (
		.clk   (clk),
		.we    (issue && tx_push),
		.waddr (ptr_slot(tx_tail_q)),
		.wdata (cmd.host_byte),
		.raddr (ptr_slot(tx_head_q)),
		.rdata (tx_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rx_head_q   <= '0;
			rx_tail_q   <= '0;
			tx_head_q   <= '0;
			tx_tail_q   <= '0;
			open_q      <= 1'b0;
			rdy_en_q    <= 1'b0;
			emp_en_q    <= 1'b0;
			valid_s2    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (issue) begin
				rx_head_q <= n_rx_head;
				rx_tail_q <= n_rx_tail;
				tx_head_q <= n_tx_head;
				tx_tail_q <= n_tx_tail;
				open_q    <= n_open;
				rdy_en_q  <= n_rdy;
				emp_en_q  <= n_emp;
			end
			valid_s2 <= issue;
			if (valid_s2) begin
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Bytes arrive from the rings in the cycle after issue; fill them in at the output.
	always_ff @(posedge clk) begin
		if (issue) begin
			res_s2 <= '{status: status, read_byte: '0, read_valid: rx_pop,
			            tx_byte: '0, tx_valid: tx_pop, taken: taken,
			            ready_en: n_rdy, empty_en: n_emp,
			            rx_fill: fill_out(ptr_fill(n_rx_head, n_rx_tail)),
			            tx_fill: fill_out(ptr_fill(n_tx_head, n_tx_tail))};
			rx_pop_s2 <= rx_pop;
			tx_pop_s2 <= tx_pop;
		end
		if (valid_s2) begin
			out_q <= res_fin;
		end
	end

	always_comb begin
		res_fin           = res_s2;
		res_fin.read_byte = rx_pop_s2 ? rx_rdata : 8'd0;
		res_fin.tx_byte   = tx_pop_s2 ? tx_rdata : 8'd0;
	end

	assign empty = !out_valid_q;
	assign res   = out_q;

endmodule

### rtl/buffered_uart_ring_frontend.sv
// ----------------------------------------------------------------------------
// buffered_uart_ring_frontend: buffered host front end for a serial line
// Receive and transmit rings with open/close and interrupt-enable control.
//
//   channel   handshake        payload
//   request   push / full      func, host_byte, line_data_ready,
//                              line_thr_empty, line_rx_byte
//   result    empty / pop      result_status, read_byte, read_valid,
//                              line_tx_byte, line_tx_valid, rx_byte_taken,
//                              ready_int_enable, empty_int_enable, rx_fill, tx_fill
//
// A request passes the command queue, the ring read stage and the output register
// before it shows up as a result. The back end takes no new command until the last
// one has its registered ring RAM read back.
// Requests queue in a two-entry command queue; full rises when it holds two.
// A result not popped holds the back end; the queue keeps accepting until full.
// Reset clears pointers, open flag and enables; ring contents are not cleared.
// ----------------------------------------------------------------------------
module buffered_uart_ring_frontend (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         push,
	output logic                         full,
	input  logic [2:0]                   func,
	input  logic [7:0]                   host_byte,
	input  logic                         line_data_ready,
	input  logic                         line_thr_empty,
	input  logic [7:0]                   line_rx_byte,
	output logic                         empty,
	input  logic                         pop,
	output logic [2:0]                   result_status,
	output logic [7:0]                   read_byte,
	output logic                         read_valid,
	output logic [7:0]                   line_tx_byte,
	output logic                         line_tx_valid,
	output logic                         rx_byte_taken,
	output logic                         ready_int_enable,
	output logic                         empty_int_enable,
	output logic [buart_pkg::FILL_W-1:0] rx_fill,
	output logic [buart_pkg::FILL_W-1:0] tx_fill
);
	import buart_pkg::*;

	cmd_t cmd;
	logic cmd_valid;
	logic cmd_take;
	res_t res;

	buart_front u_front (
		.clk             (clk),
		.arst_n          (arst_n),
		.push            (push),
		.full            (full),
		.func            (func),
		.host_byte       (host_byte),
		.line_data_ready (line_data_ready),
		.line_thr_empty  (line_thr_empty),
		.line_rx_byte    (line_rx_byte),
		.cmd             (cmd),
		.cmd_valid       (cmd_valid),
		.cmd_take        (cmd_take)
	);

	buart_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.cmd_valid (cmd_valid),
		.cmd_take  (cmd_take),
		.empty     (empty),
		.pop       (pop),
		.res       (res)
	);

	assign result_status    = res.status;
	assign read_byte        = res.read_byte;
	assign read_valid       = res.read_valid;
	assign line_tx_byte     = res.tx_byte;
	assign line_tx_valid    = res.tx_valid;
	assign rx_byte_taken    = res.taken;
	assign ready_int_enable = res.ready_en;
	assign empty_int_enable = res.empty_en;
	assign rx_fill          = res.rx_fill;
	assign tx_fill          = res.tx_fill;

`ifndef SYNTHESIS
	// A popped byte only comes with a clean status.
	a_read_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && read_valid) |-> (result_status == ST_OK))
		else $error("read byte with non-ok status");

	// A host read never moves line bytes in the same transfer.
	a_read_excl: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && read_valid) |-> (!line_tx_valid && !rx_byte_taken))
		else $error("read overlaps line service");

	// A closed block keeps both interrupts disabled.
	a_closed_en: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && result_status == ST_CLOSED) |-> (!ready_int_enable && !empty_int_enable))
		else $error("interrupt enabled while closed");

	// A rejected write still arms the transmit interrupt.
	a_full_en: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && result_status == ST_TX_FULL) |-> empty_int_enable)
		else $error("transmit interrupt not armed on full ring");
`endif

endmodule
